// ===== hdl/cmst_pkg.sv =====
// ----------------------------------------------------------------------------
// cmst_pkg
// Field widths and codes for the CAN message slot table.
// ----------------------------------------------------------------------------
package cmst_pkg;

  localparam int ACTION_W  = 2;
  localparam int ID_W      = 11;
  localparam int DATA_W    = 64;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 3;
  localparam int OUTCOME_W = 2;
  localparam int COUNT_W   = 4;
  localparam int WINDOW_W  = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STATUS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_SLOT = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_REPLACED = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_QUERY    = 2'd3;

endpackage

// ===== hdl/cmst_if.sv =====
// ----------------------------------------------------------------------------
// cmst_in_if / cmst_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cmst_in_if;
  logic                          valid;
  logic                          ready;
  logic [cmst_pkg::ACTION_W-1:0] action;
  logic [cmst_pkg::ID_W-1:0]     msg_id;
  logic [cmst_pkg::DATA_W-1:0]   payload;
  logic [cmst_pkg::TIME_W-1:0]   now;
  logic [cmst_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, action, msg_id, payload, now, slot, input ready);
  modport sink   (input valid, action, msg_id, payload, now, slot, output ready);
endinterface

interface cmst_out_if;
  logic                           valid;
  logic                           ready;
  logic [cmst_pkg::OUTCOME_W-1:0] outcome;
  logic [cmst_pkg::SLOT_W-1:0]    slot_used;
  logic [cmst_pkg::ID_W-1:0]      evicted_id;
  logic                           entry_valid;
  logic [cmst_pkg::ID_W-1:0]      entry_id;
  logic [cmst_pkg::DATA_W-1:0]    entry_payload;
  logic [cmst_pkg::TIME_W-1:0]    entry_time;
  logic [cmst_pkg::COUNT_W-1:0]   entry_count;
  logic                           is_empty;
  logic                           is_online;

  modport source (output valid, outcome, slot_used, evicted_id, entry_valid, entry_id,
                  entry_payload, entry_time, entry_count, is_empty, is_online,
                  input ready);
  modport sink   (input valid, outcome, slot_used, evicted_id, entry_valid, entry_id,
                  entry_payload, entry_time, entry_count, is_empty, is_online,
                  output ready);
endinterface

// ===== hdl/can_message_slot_table.sv =====
// Flow: a store scans the slots serially over one memory read port and one compare unit,
//   stopping at the first slot that matches or is free, else replacing after the last slot;
//   a status query goes straight to ST_DONE; a slot read passes through ST_READ first.
// Throughput: one item at a time; the next item is taken the cycle after the result
//   is loaded into the output register.
// Reset: synchronous active-low rst_n clears all slot valid bits, the count, the
//   last-receive time and the output valid, and sets the window to 500.
// ----------------------------------------------------------------------------
// can_message_slot_table
// Table of received CAN frames keyed by standard ID, with same-ID update,
// first-free fill and oldest-stamp replacement, plus status and slot read.
// ----------------------------------------------------------------------------
module can_message_slot_table #(
  parameter int ENTRIES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cmst_pkg::WINDOW_W-1:0]     cfg_data,
  cmst_in_if.sink                           in_ch,
  cmst_out_if.source                        out_ch
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  typedef struct packed {
    logic [cmst_pkg::ID_W-1:0]   id;
    logic [cmst_pkg::DATA_W-1:0] data;
    logic [cmst_pkg::TIME_W-1:0] stamp;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state_r;

  // slot storage
  slot_t            mem [ENTRIES];
  slot_t            rdata_r;
  logic [IDXW-1:0]  raddr;
  logic             mem_we;
  logic [IDXW-1:0]  mem_waddr;
  slot_t            mem_wdata;

  logic [ENTRIES-1:0]            vld_r;
  logic [CNTW-1:0]               count_r;
  logic [cmst_pkg::TIME_W-1:0]   last_rx_r;
  logic [cmst_pkg::WINDOW_W-1:0] window_r;

  // latched request
  logic [cmst_pkg::ID_W-1:0]   id_r;
  logic [cmst_pkg::DATA_W-1:0] data_r;
  logic [cmst_pkg::TIME_W-1:0] now_r;
  logic [IDXW-1:0]             rslot_r;
  logic                        in_range_r;

  // scan state
  logic [IDXW-1:0]             idx_r;
  logic [IDXW-1:0]             best_idx_r;
  logic [cmst_pkg::TIME_W-1:0] best_stamp_r;
  logic [cmst_pkg::ID_W-1:0]   best_id_r;

  // result fields
  logic [cmst_pkg::OUTCOME_W-1:0] res_outcome_r;
  logic [IDXW-1:0]                res_slot_r;
  logic [cmst_pkg::ID_W-1:0]      res_evicted_r;
  logic                           res_ev_r;
  logic [cmst_pkg::ID_W-1:0]      res_eid_r;
  logic [cmst_pkg::DATA_W-1:0]    res_edata_r;
  logic [cmst_pkg::TIME_W-1:0]    res_etime_r;

  logic                           out_valid_r;
  logic [cmst_pkg::OUTCOME_W-1:0] out_outcome_r;
  logic [cmst_pkg::SLOT_W-1:0]    out_slot_r;
  logic [cmst_pkg::ID_W-1:0]      out_evicted_r;
  logic                           out_ev_r;
  logic [cmst_pkg::ID_W-1:0]      out_eid_r;
  logic [cmst_pkg::DATA_W-1:0]    out_edata_r;
  logic [cmst_pkg::TIME_W-1:0]    out_etime_r;
  logic [cmst_pkg::COUNT_W-1:0]   out_count_r;
  logic                           out_empty_r;
  logic                           out_online_r;

  logic                        in_xfer;
  logic [IDXW-1:0]             in_slot_idx;
  logic                        cur_vld;
  logic                        hit;
  logic                        take_slot;
  logic                        better;
  logic                        evict;
  logic [IDXW-1:0]             best_idx_nxt;
  logic [cmst_pkg::TIME_W-1:0] best_stamp_nxt;
  logic [cmst_pkg::ID_W-1:0]   best_id_nxt;
  logic [cmst_pkg::TIME_W-1:0] age;
  logic                        out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_slot_idx = IDXW'(in_ch.slot);
  assign out_free    = !out_valid_r || out_ch.ready;

  // one compare pair per scan step: ID match and stamp minimum
  always_comb begin
    cur_vld        = vld_r[idx_r];
    hit            = cur_vld && (rdata_r.id == id_r);
    take_slot      = (state_r == ST_SCAN) && (hit || !cur_vld);
    better         = (idx_r == '0) || (rdata_r.stamp < best_stamp_r);
    best_idx_nxt   = better ? idx_r : best_idx_r;
    best_stamp_nxt = better ? rdata_r.stamp : best_stamp_r;
    best_id_nxt    = better ? rdata_r.id : best_id_r;
    evict          = (state_r == ST_SCAN) && !(hit || !cur_vld) && (idx_r == LAST_IDX);
    mem_we         = take_slot || evict;
    mem_waddr      = take_slot ? idx_r : best_idx_nxt;
    mem_wdata      = '{id: id_r, data: data_r, stamp: now_r};
    age            = now_r - last_rx_r;
    case (state_r)
      ST_IDLE: raddr = (in_ch.action == cmst_pkg::ACT_READ) ? in_slot_idx : '0;
      ST_SCAN: raddr = idx_r + 1'b1;
      default: raddr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      count_r     <= '0;
      last_rx_r   <= '0;
      window_r    <= cmst_pkg::WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_data;
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            id_r          <= in_ch.msg_id;
            data_r        <= in_ch.payload;
            now_r         <= in_ch.now;
            rslot_r       <= in_slot_idx;
            in_range_r    <= (32'(in_ch.slot) < 32'(ENTRIES));
            idx_r         <= '0;
            res_outcome_r <= cmst_pkg::OUT_QUERY;
            res_slot_r    <= '0;
            res_evicted_r <= '0;
            res_ev_r      <= 1'b0;
            res_eid_r     <= '0;
            res_edata_r   <= '0;
            res_etime_r   <= '0;
            case (in_ch.action)
              cmst_pkg::ACT_STORE:  state_r <= ST_SCAN;
              cmst_pkg::ACT_STATUS: state_r <= ST_DONE;
              cmst_pkg::ACT_READ:   state_r <= ST_READ;
              default:              state_r <= ST_IDLE;  // drop unused action
            endcase
          end
        end
        ST_SCAN: begin
          best_idx_r   <= best_idx_nxt;
          best_stamp_r <= best_stamp_nxt;
          best_id_r    <= best_id_nxt;
          idx_r        <= idx_r + 1'b1;
          if (take_slot) begin
            vld_r[idx_r]  <= 1'b1;
            last_rx_r     <= now_r;
            res_slot_r    <= idx_r;
            res_outcome_r <= hit ? cmst_pkg::OUT_UPDATED : cmst_pkg::OUT_NEW_SLOT;
            if (!hit) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= ST_DONE;
          end else if (evict) begin
            last_rx_r     <= now_r;
            res_slot_r    <= best_idx_nxt;
            res_evicted_r <= best_id_nxt;
            res_outcome_r <= cmst_pkg::OUT_REPLACED;
            state_r       <= ST_DONE;
          end
        end
        ST_READ: begin
          if (in_range_r && vld_r[rslot_r]) begin
            res_ev_r    <= 1'b1;
            res_eid_r   <= rdata_r.id;
            res_edata_r <= rdata_r.data;
            res_etime_r <= rdata_r.stamp;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // status fields see the table after this item's update
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_outcome_r <= res_outcome_r;
            out_slot_r    <= cmst_pkg::SLOT_W'(res_slot_r);
            out_evicted_r <= res_evicted_r;
            out_ev_r      <= res_ev_r;
            out_eid_r     <= res_eid_r;
            out_edata_r   <= res_edata_r;
            out_etime_r   <= res_etime_r;
            out_count_r   <= cmst_pkg::COUNT_W'(count_r);
            out_empty_r   <= (count_r == '0);
            out_online_r  <= (age < 32'(window_r));
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.outcome       = out_outcome_r;
  assign out_ch.slot_used     = out_slot_r;
  assign out_ch.evicted_id    = out_evicted_r;
  assign out_ch.entry_valid   = out_ev_r;
  assign out_ch.entry_id      = out_eid_r;
  assign out_ch.entry_payload = out_edata_r;
  assign out_ch.entry_time    = out_etime_r;
  assign out_ch.entry_count   = out_count_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.is_online     = out_online_r;

endmodule
